// ===== src/sorted_job_list_best_fit_core_macros.svh =====
// assertion macros for the sorted job list core
// used by the top level only, no other dependencies
`ifndef SORTED_JOB_LIST_BEST_FIT_CORE_MACROS_SVH
`define SORTED_JOB_LIST_BEST_FIT_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SJL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SJL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sjl_pkg.sv =====
// shared types and constants for the sorted job list core
// no dependencies
package sjl_pkg;

	localparam int SIZE_BITS = 16;
	localparam int ID_BITS   = 8;
	localparam int IDX_BITS  = 4;
	localparam int CNT_BITS  = 5;
	// number of cells in the row, tied to the index and count field widths
	localparam int CAPACITY  = 16;

	localparam int IN_DATA_BITS  = 48;
	localparam int IN_USER_BITS  = 2;
	localparam int OUT_DATA_BITS = 56;
	localparam int OUT_USER_BITS = 2;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_NOFIT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] size;
		logic [ID_BITS-1:0]   id;
	} entry_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t             op;
		entry_t               ins;
		logic [SIZE_BITS-1:0] hole;
	} cell_ctrl_t;

endpackage

// ===== src/sjl_cell.sv =====
// one position of the sorted job list: holds a single entry
// and shifts to or from its neighbors; depends on sjl_pkg
module sjl_cell
	import sjl_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       valid,
	input  logic       sel,
	input  entry_t     left_data,
	input  entry_t     right_data,
	input  logic       left_ge,
	input  logic       rm_in,
	output entry_t     data,
	output logic       ge,
	output logic       fit,
	output logic       rm_out
);

	entry_t data_q;
	entry_t data_d;

	// new entry goes at or before this cell
	assign ge     = !valid || (data_q.size > ctrl.ins.size);
	assign fit    = valid && (data_q.size <= ctrl.hole);
	assign rm_out = rm_in || sel;
	assign data   = data_q;

	always_comb begin
		data_d = data_q;
		unique case (ctrl.op)
			CELL_HOLD: data_d = data_q;
			CELL_INSERT: begin
				priority if (left_ge) begin
					data_d = left_data;
				end else if (ge) begin
					data_d = ctrl.ins;
				end else begin
					data_d = data_q;
				end
			end
			CELL_REMOVE: begin
				if (rm_out) begin
					data_d = right_data;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

// ===== src/sorted_job_list_best_fit_core.sv =====
// top level of the sorted job list with best-fit search
// depends on sjl_pkg, sjl_cell and sorted_job_list_best_fit_core_macros.svh
//
// Keeps up to CAPACITY jobs (id and size) in a row of cells sorted by size, smallest
// first, older entries first among equal sizes. Each request word on the slave side
// gives exactly one result word on the master side, in the cycle after it is taken. Every
// request (insert, remove at index, find fit, read at index) is handled by the whole row at once:
// each cell compares its own entry against the broadcast request and shifts in from its
// left or right neighbor, so a new request can be taken every cycle as long as the
// result register is empty or being drained. Insert places the job after all equal sizes
// and reports list full when the row is occupied; remove closes the gap; find fit
// returns the highest position whose size is at most the hole. The result always carries
// the count and the largest size after the request. No clearing pass follows reset.
`include "sorted_job_list_best_fit_core_macros.svh"

module sorted_job_list_best_fit_core
	import sjl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// job_id[7:0], job_size[23:8], entry_index[27:24], hole_size[43:28], zeros above
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
	// req_type[1:0]
	input  logic [IN_USER_BITS-1:0]  s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// found_index[3:0], out_job_id[11:4], out_job_size[27:12], entry_count[32:28],
	// largest_size[48:33], is_empty[49], zeros above
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	// status[1:0]
	output logic [OUT_USER_BITS-1:0] m_axis_tuser
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// request fields
	req_t                 req;
	logic [ID_BITS-1:0]   in_id;
	logic [SIZE_BITS-1:0] in_size;
	logic [IDX_BITS-1:0]  in_idx;
	logic [SIZE_BITS-1:0] in_hole;
	logic                 in_fire;

	assign req     = req_t'(s_axis_tuser[1:0]);
	assign in_id   = s_axis_tdata[7:0];
	assign in_size = s_axis_tdata[23:8];
	assign in_idx  = s_axis_tdata[27:24];
	assign in_hole = s_axis_tdata[43:28];

	// list state
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_d;
	logic [SIZE_BITS-1:0] largest_q;
	logic [SIZE_BITS-1:0] largest_d;

	// result register
	logic                 m_valid_q;
	status_t              out_status_q;
	logic [IDX_BITS-1:0]  out_idx_q;
	entry_t               out_entry_q;
	logic [CNT_BITS-1:0]  out_count_q;
	logic [SIZE_BITS-1:0] out_largest_q;
	logic                 out_empty_q;

	// row of cells
	cell_ctrl_t           ctrl;
	cell_op_t             op;
	entry_t               cell_data [CAPACITY];
	logic [CAPACITY-1:0]  cell_valid;
	logic [CAPACITY-1:0]  cell_sel;
	logic [CAPACITY-1:0]  cell_ge;
	logic [CAPACITY-1:0]  cell_ge_left;
	logic [CAPACITY-1:0]  cell_fit;
	logic [CAPACITY-1:0]  cell_fit_next;
	logic [CAPACITY-1:0]  cell_rm_in;
	logic [CAPACITY-1:0]  cell_rm_out;
	logic [CAPACITY-1:0]  cell_second;
	logic [CAPACITY-1:0]  order_ok;

	// the result word can be refilled in the cycle it drains
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign ctrl.op   = in_fire ? op : CELL_HOLD;
	assign ctrl.ins  = '{size: in_size, id: in_id};
	assign ctrl.hole = in_hole;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		entry_t right_data;

		assign cell_valid[g]  = g < int'(count_q);
		assign cell_sel[g]    = int'(in_idx) == g;
		// entry just below the tail, the new tail when the tail is removed
		assign cell_second[g] = int'(count_q) == g + 2;

		if (g == 0) begin : g_first
			assign cell_ge_left[g] = 1'b0;
			assign cell_rm_in[g]   = 1'b0;
			assign order_ok[g]     = 1'b1;
		end else begin : g_inner
			assign cell_ge_left[g] = cell_ge[g-1];
			assign cell_rm_in[g]   = cell_rm_out[g-1];
			assign order_ok[g]     = !(cell_valid[g] &&
				(cell_data[g-1].size > cell_data[g].size));
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_data       = cell_data[g];
			assign cell_fit_next[g] = 1'b0;
		end else begin : g_mid
			assign right_data       = cell_data[g+1];
			assign cell_fit_next[g] = cell_fit[g+1];
		end

		sjl_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.valid      (cell_valid[g]),
			.sel        (cell_sel[g]),
			.left_data  ((g == 0) ? cell_data[g] : cell_data[(g == 0) ? 0 : g-1]),
			.right_data (right_data),
			.left_ge    (cell_ge_left[g]),
			.rm_in      (cell_rm_in[g]),
			.data       (cell_data[g]),
			.ge         (cell_ge[g]),
			.fit        (cell_fit[g]),
			.rm_out     (cell_rm_out[g])
		);
	end

	// one-hot picks across the row, folded into index and entry
	logic [IDX_BITS-1:0]  ins_idx;
	logic [IDX_BITS-1:0]  fit_idx;
	logic                 fit_any;
	entry_t               fit_entry;
	entry_t               rd_entry;
	logic [SIZE_BITS-1:0] second_size;

	always_comb begin
		ins_idx     = '0;
		fit_idx     = '0;
		fit_any     = 1'b0;
		fit_entry   = '0;
		rd_entry    = '0;
		second_size = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			// first cell where the new entry belongs
			if (cell_ge[i] && !cell_ge_left[i]) begin
				ins_idx = ins_idx | IDX_BITS'(i);
			end
			// last fitting cell, fits form a prefix of the sorted row
			if (cell_fit[i] && !cell_fit_next[i]) begin
				fit_idx   = fit_idx | IDX_BITS'(i);
				fit_any   = 1'b1;
				fit_entry = fit_entry | cell_data[i];
			end
			if (cell_sel[i] && cell_valid[i]) begin
				rd_entry = rd_entry | cell_data[i];
			end
			if (cell_second[i]) begin
				second_size = second_size | cell_data[i].size;
			end
		end
	end

	// request decode
	status_t             res_status;
	logic [IDX_BITS-1:0] res_idx;
	entry_t              res_entry;
	logic                in_range;
	logic                is_tail;
	logic                ins_taken;

	assign in_range  = int'(in_idx) < int'(count_q);
	assign is_tail   = int'(in_idx) + 1 == int'(count_q);
	assign ins_taken = in_fire && req == REQ_INSERT && int'(count_q) != CAPACITY;

	always_comb begin
		res_status = ST_OK;
		res_idx    = '0;
		res_entry  = '0;
		count_d    = count_q;
		largest_d  = largest_q;
		op         = CELL_HOLD;
		unique case (req)
			REQ_INSERT: begin
				if (int'(count_q) == CAPACITY) begin
					res_status = ST_FULL;
				end else begin
					op        = CELL_INSERT;
					res_idx   = ins_idx;
					res_entry = ctrl.ins;
					count_d   = count_q + 1'b1;
					// a new tail when nothing held is larger
					if (count_q == '0 || in_size >= largest_q) begin
						largest_d = in_size;
					end
				end
			end
			REQ_FIND: begin
				if (fit_any) begin
					res_idx   = fit_idx;
					res_entry = fit_entry;
				end else begin
					res_status = ST_NOFIT;
				end
			end
			REQ_REMOVE: begin
				if (!in_range) begin
					res_status = ST_RANGE;
				end else begin
					op        = CELL_REMOVE;
					res_idx   = in_idx;
					res_entry = rd_entry;
					count_d   = count_q - 1'b1;
					if (is_tail) begin
						largest_d = (count_q == CNT_W'(1)) ? '0 : second_size;
					end
				end
			end
			REQ_READ: begin
				if (!in_range) begin
					res_status = ST_RANGE;
				end else begin
					res_idx   = in_idx;
					res_entry = rd_entry;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			largest_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q   <= count_d;
				largest_q <= largest_d;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_status_q  <= res_status;
			out_idx_q     <= res_idx;
			out_entry_q   <= res_entry;
			out_count_q   <= CNT_BITS'(count_d);
			out_largest_q <= largest_d;
			out_empty_q   <= (count_d == '0);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {6'b0, out_empty_q, out_largest_q, out_count_q,
		out_entry_q.size, out_entry_q.id, out_idx_q};

	// checks on the list state
	`SJL_ASSERT(a_count_bound, clk, arst_n, int'(count_q) <= CAPACITY, "count above capacity")
	`SJL_ASSERT(a_row_sorted, clk, arst_n, &order_ok, "held entries out of size order")
	`SJL_ASSERT(a_empty_largest, clk, arst_n, count_q != '0 || largest_q == '0, "empty largest")
	`SJL_ASSERT_NEXT(a_insert_count, clk, arst_n, ins_taken, count_q == $past(count_q) + 1'b1, "no grow")
	`SJL_ASSERT(a_empty_flag, clk, arst_n, !m_valid_q || (out_empty_q == (out_count_q == '0)), "empty")

endmodule

// ===== tb/sv/job_list_tb_pkg.sv =====
`timescale 1ns / 100ps
// request and reply words plus the scoreboard for the sorted job list core:
// a shadow copy of the list predicts each reply, replies are checked in order
// depends on sjl_pkg
package job_list_tb_pkg;
	import sjl_pkg::*;

	localparam int LIST_DEPTH = CAPACITY;

	typedef struct packed {
		req_t                 kind;
		logic [ID_BITS-1:0]   job_id;
		logic [SIZE_BITS-1:0] job_size;
		logic [IDX_BITS-1:0]  entry_index;
		logic [SIZE_BITS-1:0] hole_size;
	} job_request_t;

	typedef struct packed {
		status_t              status;
		logic [IDX_BITS-1:0]  found_index;
		logic [ID_BITS-1:0]   job_id;
		logic [SIZE_BITS-1:0] job_size;
		logic [CNT_BITS-1:0]  entry_count;
		logic [SIZE_BITS-1:0] largest_size;
		logic                 is_empty;
	} job_reply_t;

	class job_list_scoreboard;
		logic [SIZE_BITS-1:0] shadow_size[LIST_DEPTH];
		logic [ID_BITS-1:0]   shadow_id[LIST_DEPTH];
		int                   shadow_count;
		job_reply_t           pending_replies[$];
		int                   errors;
		int                   kind_seen[4];
		int                   status_seen[4];

		function new();
			shadow_count = 0;
			errors = 0;
			foreach (kind_seen[k]) begin
				kind_seen[k] = 0;
				status_seen[k] = 0;
			end
		endfunction

		// apply one accepted request to the shadow list and queue its reply
		function void take_request(job_request_t r);
			job_reply_t rep;
			int pos;
			int k;
			rep = '0;
			rep.status = ST_OK;
			case (r.kind)
				REQ_INSERT: begin
					if (shadow_count >= LIST_DEPTH) begin
						rep.status = ST_FULL;
					end else begin
						// new job goes after every held job of equal or smaller size
						pos = shadow_count;
						while (pos > 0 && shadow_size[pos-1] > r.job_size) begin
							shadow_size[pos] = shadow_size[pos-1];
							shadow_id[pos] = shadow_id[pos-1];
							pos--;
						end
						shadow_size[pos] = r.job_size;
						shadow_id[pos] = r.job_id;
						shadow_count++;
						rep.found_index = IDX_BITS'(pos);
						rep.job_id = r.job_id;
						rep.job_size = r.job_size;
					end
				end
				REQ_FIND: begin
					rep.status = ST_NOFIT;
					for (k = shadow_count - 1; k >= 0; k--) begin
						if (shadow_size[k] <= r.hole_size) begin
							rep.status = ST_OK;
							rep.found_index = IDX_BITS'(k);
							rep.job_id = shadow_id[k];
							rep.job_size = shadow_size[k];
							break;
						end
					end
				end
				default: begin
					if (r.entry_index >= shadow_count) begin
						rep.status = ST_RANGE;
					end else begin
						rep.found_index = r.entry_index;
						rep.job_id = shadow_id[r.entry_index];
						rep.job_size = shadow_size[r.entry_index];
						if (r.kind == REQ_REMOVE) begin
							// close the gap, order of the rest kept
							for (k = r.entry_index; k + 1 < shadow_count; k++) begin
								shadow_size[k] = shadow_size[k+1];
								shadow_id[k] = shadow_id[k+1];
							end
							shadow_count--;
						end
					end
				end
			endcase
			rep.entry_count = CNT_BITS'(shadow_count);
			rep.largest_size = (shadow_count > 0) ? shadow_size[shadow_count-1] : '0;
			rep.is_empty = (shadow_count == 0);
			kind_seen[r.kind]++;
			status_seen[rep.status]++;
			pending_replies = {pending_replies, rep};
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// check one accepted reply against the oldest queued prediction
		function void check_reply(job_reply_t got);
			job_reply_t want;
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply, expected nothing, got %0h", $time, got);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("found_index", want.found_index, got.found_index);
			compare_field("out_job_id", want.job_id, got.job_id);
			compare_field("out_job_size", want.job_size, got.job_size);
			compare_field("entry_count", want.entry_count, got.entry_count);
			compare_field("largest_size", want.largest_size, got.largest_size);
			compare_field("is_empty", want.is_empty, got.is_empty);
		endfunction
	endclass

endpackage

// ===== tb/sv/sorted_job_list_best_fit_core_test.sv =====
`timescale 1ns / 100ps
// top of the testbench for sorted_job_list_best_fit_core: clock, reset, request
// driver, reply sink with random stalls, monitor and watchdog
// depends on sjl_pkg, job_list_tb_pkg and the core itself
module sorted_job_list_best_fit_core_test;
	import sjl_pkg::*;
	import job_list_tb_pkg::*;

	localparam int QUIET_LIMIT     = 4000; // cycles with no word moving on either side
	localparam int ITEMS_PER_PHASE = 300;
	localparam int LONG_HOLD       = 80;   // long sink stall so the core backs up
	localparam int SETTLE_CYCLES   = 8;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
	logic [IN_USER_BITS-1:0]  s_axis_tuser = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic [OUT_USER_BITS-1:0] m_axis_tuser;

	job_list_scoreboard board = new();

	// idle rates in percent for the request side and the reply side
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_left = 0;
	int quiet_cycles = 0;
	bit filling = 1'b1;

	sorted_job_list_best_fit_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// reply sink: either a long counted hold or a random stall each cycle
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: both handshakes are sampled at the edge, before any update lands,
	// so the request word is noted and the reply word checked race free
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				board.take_request('{
					kind:        req_t'(s_axis_tuser),
					job_id:      s_axis_tdata[7:0],
					job_size:    s_axis_tdata[23:8],
					entry_index: s_axis_tdata[27:24],
					hole_size:   s_axis_tdata[43:28]
				});
			end
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_reply('{
					status:       status_t'(m_axis_tuser),
					found_index:  m_axis_tdata[3:0],
					job_id:       m_axis_tdata[11:4],
					job_size:     m_axis_tdata[27:12],
					entry_count:  m_axis_tdata[32:28],
					largest_size: m_axis_tdata[48:33],
					is_empty:     m_axis_tdata[49]
				});
			end
			// watchdog: a correct core never goes this long without moving a word
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("%0t: watchdog, no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// offer one request word, with random idle cycles in front, and hold it until taken;
	// valid stays high from word to word when no idle cycle falls between them
	task automatic send_request(input req_t kind, input logic [7:0] job_id,
		input logic [15:0] job_size, input logic [3:0] entry_index,
		input logic [15:0] hole_size);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, hole_size, entry_index, job_size, job_id};
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering until every predicted reply has come back
	task automatic drain_replies();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending_replies.size() != 0) @(posedge clk);
	endtask

	// sizes and holes: extremes, a coarse grid that gives many equal sizes,
	// values just under the grid, and anything at all
	function automatic logic [15:0] pick_size();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3, 4, 5: return 16'($urandom_range(7)) << 13;
			6: return 16'(($urandom_range(7) << 13) - 1);
			default: return 16'($urandom);
		endcase
	endfunction

	// random requests; the mix swings between filling and emptying the list so
	// that full and empty are both hit again and again
	task automatic random_phase(input int n_items);
		req_t kind;
		int roll;
		logic [3:0] idx;
		for (int n = 0; n < n_items; n++) begin
			if (board.shadow_count == LIST_DEPTH && $urandom_range(2) == 0)
				filling = 1'b0;
			else if (board.shadow_count == 0 && $urandom_range(2) == 0)
				filling = 1'b1;
			roll = $urandom_range(99);
			if (filling)
				kind = (roll < 55) ? REQ_INSERT : (roll < 70) ? REQ_FIND :
					(roll < 85) ? REQ_READ : REQ_REMOVE;
			else
				kind = (roll < 20) ? REQ_INSERT : (roll < 35) ? REQ_FIND :
					(roll < 50) ? REQ_READ : REQ_REMOVE;
			// mostly a held position, sometimes any index at all
			if (board.shadow_count > 0 && $urandom_range(9) != 0)
				idx = 4'($urandom_range(board.shadow_count - 1));
			else
				idx = 4'($urandom_range(15));
			send_request(kind, 8'($urandom_range(255)), pick_size(), idx, pick_size());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list corner cases
		send_request(REQ_READ, 8'h00, 16'h0000, 4'd0, 16'h0000);   // read past count
		send_request(REQ_REMOVE, 8'h00, 16'h0000, 4'd15, 16'h0000); // remove past count
		send_request(REQ_FIND, 8'h00, 16'h0000, 4'd0, 16'hFFFF);    // nothing to fit
		// extremes of id and size, equal sizes keep arrival order
		send_request(REQ_INSERT, 8'hFF, 16'hFFFF, 4'd0, 16'h0000);
		send_request(REQ_INSERT, 8'h00, 16'h0000, 4'd0, 16'h0000);
		send_request(REQ_INSERT, 8'hAA, 16'h0000, 4'd0, 16'h0000);
		// best fit at the boundaries of the hole
		send_request(REQ_FIND, 8'h00, 16'h0000, 4'd0, 16'h0000);
		send_request(REQ_FIND, 8'h00, 16'h0000, 4'd0, 16'hFFFE);
		send_request(REQ_FIND, 8'h00, 16'h0000, 4'd0, 16'hFFFF);
		send_request(REQ_READ, 8'h00, 16'h0000, 4'd2, 16'h0000);
		send_request(REQ_READ, 8'h00, 16'h0000, 4'd3, 16'h0000);
		send_request(REQ_REMOVE, 8'h00, 16'h0000, 4'd0, 16'h0000);
		// fill the list to capacity with a few repeated sizes
		for (int i = 0; i < LIST_DEPTH - 2; i++)
			send_request(REQ_INSERT, 8'(16 + i), 16'(i % 5) * 16'h3000, 4'd0, 16'h0000);
		send_request(REQ_INSERT, 8'h5A, 16'h8000, 4'd0, 16'h0000); // list full
		send_request(REQ_READ, 8'h00, 16'h0000, 4'd15, 16'h0000);
		send_request(REQ_FIND, 8'h00, 16'h0000, 4'd0, 16'h7FFF);
		send_request(REQ_REMOVE, 8'h00, 16'h0000, 4'd15, 16'h0000);
		send_request(REQ_REMOVE, 8'h00, 16'h0000, 4'd0, 16'h0000);
		drain_replies();

		// slow sink, busy source
		tx_idle_pct = 19;
		rx_idle_pct = 86;
		random_phase(ITEMS_PER_PHASE);
		drain_replies();

		// slow source, busy sink
		tx_idle_pct = 86;
		rx_idle_pct = 19;
		random_phase(ITEMS_PER_PHASE);
		drain_replies();

		// no idling at all, opened by a long sink hold so the core stalls its input
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = LONG_HOLD;
		random_phase(ITEMS_PER_PHASE);
		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d requests: %0d insert, %0d remove, %0d find fit, %0d read",
			board.kind_seen[REQ_INSERT] + board.kind_seen[REQ_REMOVE] +
			board.kind_seen[REQ_FIND] + board.kind_seen[REQ_READ],
			board.kind_seen[REQ_INSERT], board.kind_seen[REQ_REMOVE],
			board.kind_seen[REQ_FIND], board.kind_seen[REQ_READ]);
		$display("replies: %0d ok, %0d list full, %0d index beyond count, %0d no fit; %0d mismatches",
			board.status_seen[ST_OK], board.status_seen[ST_FULL],
			board.status_seen[ST_RANGE], board.status_seen[ST_NOFIT], board.errors);
		if (board.errors == 0 && board.pending_replies.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
